[hdl/ssm_pkg.sv]
`default_nettype none
package ssm_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int USED_W     = NODE_W + 1;
  localparam int MAX_LEN    = 32;
  localparam int POS_W      = $clog2(MAX_LEN);
  localparam int LEN_W      = POS_W + 1;
  localparam int ALPHABET   = 26;
  localparam int LETTER_W   = 5;
  localparam int SLOT_DEPTH = MAX_NODES * ALPHABET;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_I_RD,
    S_I_CH,
    S_I_UPD,
    S_I_MARK,
    S_Q_RD,
    S_Q_CHK
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                input logic [LETTER_W-1:0] c);
    logic [SLOT_W-1:0] base;
    base = SLOT_W'(node) * SLOT_W'(ALPHABET);
    return base + SLOT_W'(c);
  endfunction

endpackage
`default_nettype wire

[hdl/stream_suffix_pattern_matcher.sv]
`default_nettype none
// channel | ports                               | handshake
// input   | in_mode, in_letter, in_last_of_word | start high, busy low
// result  | out_match, out_status               | out_valid strobe, one cycle
// Load letter that does not end a word: result in the cycle after the beat.
// Word end: per stored letter the FSM steps through S_I_RD, S_I_CH and S_I_UPD,
//   the serial pattern buffer read and child table read-modify-write, then S_I_MARK.
// Query: each trie node checked passes through S_Q_RD and S_Q_CHK.
// After reset busy stays high while all SLOT_DEPTH child table entries and the
//   word-end flags are cleared, one entry a cycle.
// The receiver cannot stall; each result is shown for one cycle only.
module stream_suffix_pattern_matcher (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire                       in_mode,
  input  wire [ssm_pkg::LETTER_W-1:0] in_letter,
  input  wire                       in_last_of_word,
  output logic                      out_valid,
  output logic                      out_match,
  output logic [1:0]                out_status
);
  import ssm_pkg::*;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]   clr_r, clr_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                bad_r, bad_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0]    head_r, head_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                ov_r, ov_nxt;
  logic                om_r, om_nxt;
  logic [1:0]          os_r, os_nxt;

  logic [NODE_W-1:0]   child_mem [SLOT_DEPTH];
  logic                flag_mem  [MAX_NODES];
  logic [LETTER_W-1:0] pbuf_mem  [MAX_LEN];
  logic [LETTER_W-1:0] hist_mem  [MAX_LEN];

  logic [NODE_W-1:0]   child_rd;
  logic                flag_rd;
  logic [LETTER_W-1:0] pbuf_rd, hist_rd;

  logic                child_we, flag_we, pbuf_we, hist_we;
  logic [SLOT_W-1:0]   child_addr;
  logic [NODE_W-1:0]   child_wd;
  logic [NODE_W-1:0]   flag_addr;
  logic                flag_wd;
  logic [POS_W-1:0]    pbuf_addr, hist_addr;

  logic accept;
  logic [POS_W-1:0] hist_rd_idx;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = ov_r;
  assign out_match   = om_r;
  assign out_status  = os_r;
  assign hist_rd_idx = head_r - POS_W'(1) - cnt_r[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_addr] <= child_wd;
    child_rd <= child_mem[child_addr];
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_addr] <= flag_wd;
    flag_rd <= flag_mem[flag_addr];
  end

  always_ff @(posedge clk) begin
    if (pbuf_we) pbuf_mem[pbuf_addr] <= in_letter;
    pbuf_rd <= pbuf_mem[pbuf_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_addr] <= in_letter;
    hist_rd <= hist_mem[hist_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == SLOT_W'(SLOT_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            state_nxt = S_Q_RD;
          end else if (in_last_of_word && !(len_r >= LEN_W'(MAX_LEN)) &&
                       !bad_r && !(in_letter >= LETTER_W'(ALPHABET))) begin
            state_nxt = S_I_RD;
          end
        end
      end
      S_I_RD:   state_nxt = S_I_CH;
      S_I_CH:   state_nxt = S_I_UPD;
      S_I_UPD: begin
        if (child_rd == '0 && used_r >= USED_W'(MAX_NODES)) state_nxt = S_IDLE;
        else if (cnt_r == LEN_W'(1)) state_nxt = S_I_MARK;
        else state_nxt = S_I_RD;
      end
      S_I_MARK: state_nxt = S_IDLE;
      S_Q_RD: begin
        if (cnt_r != '0 && child_rd == '0) state_nxt = S_IDLE;
        else state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        priority if (flag_rd || cnt_r == fill_r || hist_rd >= LETTER_W'(ALPHABET))
          state_nxt = S_IDLE;
        else
          state_nxt = S_Q_RD;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt    = clr_r;
    len_nxt    = len_r;
    bad_nxt    = bad_r;
    node_nxt   = node_r;
    used_nxt   = used_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    slot_nxt   = slot_r;
    ov_nxt     = 1'b0;
    om_nxt     = 1'b0;
    os_nxt     = ST_OK;
    child_we   = 1'b0;
    child_addr = slot_r;
    child_wd   = '0;
    flag_we    = 1'b0;
    flag_addr  = node_r;
    flag_wd    = 1'b0;
    pbuf_we    = 1'b0;
    pbuf_addr  = POS_W'(cnt_r - LEN_W'(1));
    hist_we    = 1'b0;
    hist_addr  = hist_rd_idx;
    unique case (state_r)
      S_CLEAR: begin
        child_we   = 1'b1;
        child_addr = clr_r;
        flag_we    = (clr_r < SLOT_W'(MAX_NODES));
        flag_addr  = clr_r[NODE_W-1:0];
        clr_nxt    = clr_r + SLOT_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          node_nxt = '0;
          if (in_mode) begin
            hist_we   = 1'b1;
            hist_addr = head_r;
            head_nxt  = head_r + POS_W'(1);
            if (fill_r < LEN_W'(MAX_LEN)) fill_nxt = fill_r + LEN_W'(1);
            cnt_nxt   = '0;
          end else begin
            if (len_r < LEN_W'(MAX_LEN)) begin
              pbuf_we   = 1'b1;
              pbuf_addr = len_r[POS_W-1:0];
              len_nxt   = len_r + LEN_W'(1);
              if (in_letter >= LETTER_W'(ALPHABET)) bad_nxt = 1'b1;
            end else begin
              len_nxt = LEN_W'(MAX_LEN + 1);
            end
            if (in_last_of_word) begin
              if ((len_r >= LEN_W'(MAX_LEN)) || bad_r ||
                  (in_letter >= LETTER_W'(ALPHABET))) begin
                ov_nxt  = 1'b1;
                os_nxt  = ST_DROP;
                len_nxt = '0;
                bad_nxt = 1'b0;
              end else begin
                cnt_nxt = len_r + LEN_W'(1);
                len_nxt = '0;
                bad_nxt = 1'b0;
              end
            end else begin
              ov_nxt = 1'b1;
            end
          end
        end
      end
      S_I_RD: begin
        pbuf_addr = POS_W'(cnt_r - LEN_W'(1));
      end
      S_I_CH: begin
        slot_nxt   = slot_of(node_r, pbuf_rd);
        child_addr = slot_of(node_r, pbuf_rd);
      end
      S_I_UPD: begin
        cnt_nxt = cnt_r - LEN_W'(1);
        if (child_rd == '0) begin
          if (used_r >= USED_W'(MAX_NODES)) begin
            ov_nxt = 1'b1;
            os_nxt = ST_FULL;
          end else begin
            child_we   = 1'b1;
            child_addr = slot_r;
            child_wd   = used_r[NODE_W-1:0];
            node_nxt   = used_r[NODE_W-1:0];
            used_nxt   = used_r + USED_W'(1);
          end
        end else begin
          node_nxt = child_rd;
        end
      end
      S_I_MARK: begin
        flag_we   = 1'b1;
        flag_addr = node_r;
        flag_wd   = 1'b1;
        ov_nxt    = 1'b1;
      end
      S_Q_RD: begin
        hist_addr = hist_rd_idx;
        flag_addr = node_r;
        if (cnt_r != '0) begin
          if (child_rd == '0) begin
            ov_nxt = 1'b1;
          end else begin
            node_nxt  = child_rd;
            flag_addr = child_rd;
          end
        end
      end
      S_Q_CHK: begin
        priority if (flag_rd) begin
          ov_nxt = 1'b1;
          om_nxt = 1'b1;
        end else if (cnt_r == fill_r || hist_rd >= LETTER_W'(ALPHABET)) begin
          ov_nxt = 1'b1;
        end else begin
          child_addr = slot_of(node_r, hist_rd);
          slot_nxt   = slot_of(node_r, hist_rd);
          cnt_nxt    = cnt_r + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      len_r   <= '0;
      bad_r   <= 1'b0;
      node_r  <= '0;
      used_r  <= USED_W'(1);
      cnt_r   <= '0;
      head_r  <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
      ov_r    <= 1'b0;
      om_r    <= 1'b0;
      os_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      len_r   <= len_nxt;
      bad_r   <= bad_nxt;
      node_r  <= node_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
      ov_r    <= ov_nxt;
      om_r    <= om_nxt;
      os_r    <= os_nxt;
    end
  end

endmodule
`default_nettype wire

[sim/ssm_checker.sv]
module ssm_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire                          in_mode,
  input  wire [ssm_pkg::LETTER_W-1:0]  in_letter,
  input  wire                          in_last_of_word,
  input  wire                          out_valid,
  input  wire                          out_match,
  input  wire [1:0]                    out_status,
  output int                           errors,
  output int                           pending
);
  import ssm_pkg::*;

  typedef struct packed {
    logic       match;
    logic [1:0] status;
  } verdict_t;

  logic [NODE_W-1:0]   trie_kids [SLOT_DEPTH];
  logic                is_word [MAX_NODES];
  int                  node_count;
  logic [LETTER_W-1:0] recent [MAX_LEN];
  int                  recent_fill;
  int                  recent_head;
  logic [LETTER_W-1:0] word_buf [MAX_LEN];
  int                  word_len;
  verdict_t            expected_verdicts [$];

  function automatic logic [1:0] add_word();
    int node;
    int slot;
    node = 0;
    if (word_len > MAX_LEN) return ST_DROP;
    for (int i = 0; i < word_len; i++)
      if (word_buf[i] >= ALPHABET) return ST_DROP;
    for (int i = word_len; i > 0; i--) begin
      slot = node * ALPHABET + word_buf[i-1];
      if (trie_kids[slot] == 0) begin
        if (node_count >= MAX_NODES) return ST_FULL;
        trie_kids[slot] = NODE_W'(node_count);
        node_count++;
      end
      node = trie_kids[slot];
    end
    is_word[node] = 1'b1;
    return ST_OK;
  endfunction

  function automatic logic suffix_hit(input logic [LETTER_W-1:0] c_in);
    int node;
    int c;
    node = 0;
    recent[recent_head] = c_in;
    recent_head = (recent_head + 1) % MAX_LEN;
    if (recent_fill < MAX_LEN) recent_fill++;
    for (int k = 0; k < recent_fill; k++) begin
      c = recent[(recent_head + MAX_LEN - 1 - k) % MAX_LEN];
      if (is_word[node]) return 1'b1;
      if (c >= ALPHABET) return 1'b0;
      if (trie_kids[node * ALPHABET + c] == 0) return 1'b0;
      node = trie_kids[node * ALPHABET + c];
    end
    return is_word[node];
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    verdict_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_DEPTH; i++) trie_kids[i] = '0;
      for (int i = 0; i < MAX_NODES; i++) is_word[i] = 1'b0;
      for (int i = 0; i < MAX_LEN; i++) recent[i] = '0;
      node_count = 1;
      recent_fill = 0;
      recent_head = 0;
      word_len = 0;
      errors = 0;
      expected_verdicts.delete();
      pending = 0;
    end else begin
      if (out_valid) begin
        got.match = out_match;
        got.status = out_status;
        if (expected_verdicts.size() == 0) begin
          $error("unexpected beat: match %0d status %0d", out_match, out_status);
          errors++;
        end else begin
          v = expected_verdicts.pop_front();
          if (got.match !== v.match) begin
            $error("match: expected %0d, got %0d", v.match, got.match);
            errors++;
          end
          if (got.status !== v.status) begin
            $error("status: expected %0d, got %0d", v.status, got.status);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        v = '0;
        if (in_mode) begin
          v.match = suffix_hit(in_letter);
        end else begin
          if (word_len < MAX_LEN) begin
            word_buf[word_len] = in_letter;
            word_len++;
          end else begin
            word_len = MAX_LEN + 1;
          end
          if (in_last_of_word) begin
            v.status = add_word();
            word_len = 0;
          end
        end
        expected_verdicts = {expected_verdicts, v};
      end
      pending = expected_verdicts.size();
    end
  end
endmodule

[sim/tb.sv]
module tb;
  import ssm_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int STALL_LIMIT  = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                in_mode = 1'b0;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                in_last_of_word = 1'b0;
  wire                 busy;
  wire                 out_valid;
  wire                 out_match;
  wire [1:0]           out_status;
  int                  errors;
  int                  pending;
  int                  idle_cycles = 0;
  logic [LETTER_W-1:0] vocab [8][$];

  always #10 clk = ~clk;

  stream_suffix_pattern_matcher dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_letter(in_letter), .in_last_of_word(in_last_of_word),
    .out_valid(out_valid), .out_match(out_match), .out_status(out_status)
  );

  ssm_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_letter(in_letter), .in_last_of_word(in_last_of_word),
    .out_valid(out_valid), .out_match(out_match), .out_status(out_status),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_beat(input logic mode, input logic [LETTER_W-1:0] c,
                           input logic last);
    start <= 1'b1;
    in_mode <= mode;
    in_letter <= c;
    in_last_of_word <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest();
    start <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic load_word(input int w);
    foreach (vocab[w][i]) send_beat(1'b0, vocab[w][i], i == vocab[w].size() - 1);
  endtask

  task automatic gap_maybe();
    if ($urandom_range(0, 5) == 0) rest();
  endtask

  logic [LETTER_W-1:0] az_letter;

  initial begin
    int w;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_beat(1'b1, 5'd0, 1'b0);
    send_beat(1'b0, 5'd0, 1'b1);
    send_beat(1'b1, 5'd0, 1'b0);
    send_beat(1'b0, 5'd25, 1'b0);
    send_beat(1'b0, 5'd1, 1'b1);
    send_beat(1'b1, 5'd25, 1'b0);
    send_beat(1'b1, 5'd1, 1'b0);
    send_beat(1'b0, 5'd31, 1'b1);
    send_beat(1'b1, 5'd31, 1'b0);
    send_beat(1'b1, 5'd0, 1'b0);
    send_beat(1'b0, 5'd25, 1'b0);
    send_beat(1'b0, 5'd1, 1'b1);
    for (int i = 0; i < 34; i++) send_beat(1'b0, 5'd2, i == 33);
    for (int i = 0; i < 32; i++) send_beat(1'b0, 5'(i % 26), i == 31);
    rest();
    for (int k = 0; k < 8; k++) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) vocab[k] = {vocab[k], 5'($urandom_range(0, 3))};
    end
    for (int k = 0; k < 8; k++) load_word(k);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      w = $urandom_range(0, 99);
      if (w < 70) begin
        send_beat(1'b1, 5'($urandom_range(0, 3)), 1'($urandom));
      end else if (w < 80) begin
        send_beat(1'b1, 5'($urandom), 1'($urandom));
      end else if (w < 90) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          az_letter = (j == 0 && $urandom_range(0, 9) == 0) ? 5'($urandom)
                                                             : 5'($urandom_range(0, 25));
          send_beat(1'b0, az_letter, j == n - 1);
        end
      end else begin
        n = $urandom_range(20, 40);
        for (int j = 0; j < n; j++) send_beat(1'b0, 5'($urandom_range(0, 25)), j == n - 1);
      end
      if ((i / 200) % 2 == 1) gap_maybe();
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/ssm_pkg.sv
hdl/stream_suffix_pattern_matcher.sv
sim/ssm_checker.sv
sim/tb.sv
